// ===== rtl/mmmt_pkg.sv =====
package mmmt_pkg;

    // field widths fixed by the item format
    localparam int ID_W       = 7;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 64;

    // default table size and queue depth
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH       = 2;

    // the quotient always fits in 32 bits, so the divider retires one bit per step
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // item kinds
    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_RECORD  = 2'd1,
        OP_FULL    = 2'd2,
        OP_UNKNOWN = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_UPDATE,
        BS_PREP,
        BS_DIV,
        BS_DONE
    } t_back_state;

    typedef struct packed {
        logic                     kind;
        logic [ID_W-1:0]          entry_id;
        logic signed [DATA_W-1:0] sample;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic [ID_W-1:0]          given_id;
        logic signed [DATA_W-1:0] minimum;
        logic signed [DATA_W-1:0] maximum;
        logic signed [DATA_W-1:0] mean;
        logic [DATA_W-1:0]        samples_seen;
    } t_out;

    typedef struct packed {
        t_op                      op;
        logic [ID_W-1:0]          given_id;
        logic signed [DATA_W-1:0] sample;
    } t_cmd;

    // one table entry as stored
    typedef struct packed {
        logic signed [DATA_W-1:0] minimum;
        logic signed [DATA_W-1:0] maximum;
        logic signed [SUM_W-1:0]  sum;
        logic [DATA_W-1:0]        count;
    } t_entry;

endpackage

// ===== rtl/mmmt_front.sv =====
module mmmt_front
    import mmmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in              i_in_data,
    output logic             o_in_stall,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_index
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    logic [CNT_W-1:0] r_in_use;
    logic [CNT_W-1:0] n_in_use;
    logic [CMP_W-1:0] in_use_ext;
    logic [CMP_W-1:0] next_id_ext;
    logic [CMP_W-1:0] id_ext;
    logic [CMP_W-1:0] id_m1;
    logic             table_full;
    logic             id_unknown;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // id checks against the allocation count
    always_comb begin
        in_use_ext  = CMP_W'(r_in_use);
        next_id_ext = in_use_ext + CMP_W'(1);
        id_ext      = CMP_W'(i_in_data.entry_id);
        id_m1       = id_ext - CMP_W'(1);
        table_full  = (r_in_use == CNT_W'(TABLE_ENTRIES));
        id_unknown  = (i_in_data.entry_id == '0) || (id_ext > in_use_ext);
    end

    // classify the transaction
    always_comb begin
        n_in_use       = r_in_use;
        o_cmd.sample   = i_in_data.sample;
        o_cmd.given_id = '0;
        o_index        = id_m1[IDX_W-1:0];
        if (i_in_data.kind == KIND_CREATE) begin
            o_index = r_in_use[IDX_W-1:0];
            if (table_full) begin
                o_cmd.op = OP_FULL;
            end else begin
                o_cmd.op       = OP_CREATE;
                o_cmd.given_id = next_id_ext[ID_W-1:0];
                n_in_use       = r_in_use + CNT_W'(1);
            end
        end else if (id_unknown) begin
            o_cmd.op = OP_UNKNOWN;
        end else begin
            o_cmd.op = OP_RECORD;
        end
    end

    // allocation counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (o_push) begin
            r_in_use <= n_in_use;
        end
    end

endmodule

// ===== rtl/mmmt_queue.sv =====
module mmmt_queue
    import mmmt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue pop did not drain an entry");

endmodule

// ===== rtl/mmmt_back.sv =====
module mmmt_back
    import mmmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    input  logic [IDX_W-1:0] i_q_index,
    output logic             o_q_pop,
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  logic             i_out_stall
);

    t_back_state r_state;
    t_back_state n_state;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;

    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;

    // pending result, mean filled in from the divider
    t_status                  r_res_status;
    logic [ID_W-1:0]          r_res_id;
    logic signed [DATA_W-1:0] r_res_min;
    logic signed [DATA_W-1:0] r_res_max;
    logic [DATA_W-1:0]        r_res_count;
    logic                     r_use_div;

    // divider
    logic [SUM_W-1:0]     r_div_dvd;
    logic [DATA_W-1:0]    r_div_den;
    logic                 r_div_neg;
    logic [DATA_W-1:0]    r_div_rem;
    logic [DATA_W-1:0]    r_div_num;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic             r_out_valid;
    t_out             r_out;

    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             load_out;

    logic                     sat;
    logic                     first;
    t_entry                   upd;
    logic signed [SUM_W-1:0]  smp_ext;
    logic [SUM_W-1:0]         dvd_mag;
    logic [DATA_W:0]          partial;
    logic [DATA_W+1:0]        diff;
    logic                     ge;
    logic [DATA_W-1:0]        mean_val;

    // entry update for a record
    always_comb begin
        smp_ext = SUM_W'(r_cmd.sample);
        sat     = (r_rd.count == '1);
        first   = (r_rd.count == '0);
        upd.count   = r_rd.count + DATA_W'(1);
        upd.minimum = (first || (r_cmd.sample < r_rd.minimum)) ? r_cmd.sample : r_rd.minimum;
        upd.maximum = (first || (r_cmd.sample > r_rd.maximum)) ? r_cmd.sample : r_rd.maximum;
        upd.sum     = first ? smp_ext : r_rd.sum + smp_ext;
    end

    // magnitude of the dividend and one restoring step
    always_comb begin
        dvd_mag  = r_div_dvd[SUM_W-1] ? (SUM_W'(0) - r_div_dvd) : r_div_dvd;
        partial  = {r_div_rem, r_div_num[DATA_W-1]};
        diff     = {1'b0, partial} - {2'b00, r_div_den};
        ge       = !diff[DATA_W+1];
        mean_val = '0;
        if (r_use_div) begin
            mean_val = r_div_neg ? (DATA_W'(0) - r_div_num) : r_div_num;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and table port control
    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = upd;
        load_out = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op) inside
                        OP_RECORD: begin
                            rd_en   = 1'b1;
                            n_state = BS_UPDATE;
                        end
                        OP_CREATE: begin
                            wr_en   = 1'b1;
                            wr_addr = i_q_index;
                            wr_data = '0;
                            n_state = BS_DONE;
                        end
                        OP_FULL, OP_UNKNOWN: begin
                            n_state = BS_DONE;
                        end
                        default: n_state = BS_DONE;
                    endcase
                end
            end
            BS_UPDATE: begin
                wr_en   = !sat;
                n_state = BS_PREP;
            end
            BS_PREP: begin
                n_state = BS_DIV;
            end
            BS_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // entry table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[i_q_index];
        end
    end

    // command latch, pending result and divider
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_cmd        <= i_q_cmd;
                r_idx        <= i_q_index;
                r_res_id     <= '0;
                r_res_min    <= '0;
                r_res_max    <= '0;
                r_res_count  <= '0;
                r_use_div    <= 1'b0;
                r_res_status <= ST_OK;
                case (i_q_cmd.op)
                    OP_CREATE:  r_res_id     <= i_q_cmd.given_id;
                    OP_FULL:    r_res_status <= ST_FULL;
                    OP_UNKNOWN: r_res_status <= ST_UNKNOWN;
                    default:    r_res_status <= ST_OK;
                endcase
            end
            BS_UPDATE: begin
                r_use_div <= 1'b1;
                if (sat) begin
                    r_res_status <= ST_SAT;
                    r_res_min    <= r_rd.minimum;
                    r_res_max    <= r_rd.maximum;
                    r_res_count  <= r_rd.count;
                    r_div_dvd    <= r_rd.sum;
                    r_div_den    <= r_rd.count;
                end else begin
                    r_res_status <= ST_OK;
                    r_res_min    <= upd.minimum;
                    r_res_max    <= upd.maximum;
                    r_res_count  <= upd.count;
                    r_div_dvd    <= upd.sum;
                    r_div_den    <= upd.count;
                end
            end
            BS_PREP: begin
                r_div_neg <= r_div_dvd[SUM_W-1];
                r_div_rem <= dvd_mag[SUM_W-1:DATA_W];
                r_div_num <= dvd_mag[DATA_W-1:0];
                r_div_cnt <= '1;
            end
            BS_DIV: begin
                r_div_rem <= ge ? diff[DATA_W-1:0] : partial[DATA_W-1:0];
                r_div_num <= {r_div_num[DATA_W-2:0], ge};
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.status       <= r_res_status;
            r_out.given_id     <= r_res_id;
            r_out.minimum      <= r_res_min;
            r_out.maximum      <= r_res_max;
            r_out.mean         <= mean_val;
            r_out.samples_seen <= r_res_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DIV) |-> (r_div_rem < r_div_den))
        else $error("divider remainder not below divisor");

    a_create_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.given_id != '0)) |->
        ((r_out.status == ST_OK) && (r_out.samples_seen == '0) && (r_out.mean == '0)))
        else $error("create result carries entry data");

    a_sat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_SAT)) |-> (r_out.samples_seen == '1))
        else $error("saturated status without full count");

endmodule

// ===== rtl/metric_min_max_mean_table.sv =====
// Running min/max/mean table. A create transaction hands out the next 1-based entry id (or
// reports the table full); a record transaction adds a signed Q16.16 sample to an entry and
// returns its minimum, maximum, truncated mean and sample count. Each input transaction gives
// exactly one result. A front stage checks ids against the allocation count and queues the
// classified command; the back stage owns the entry table (one read and one write port) and a
// serial divider for the mean. In the back stage a create, full or unknown-id transaction goes
// straight to the result load; a record passes through table read, update and write-back,
// dividend setup, 32 steps of the one-bit-per-cycle divider and result load. Table entries
// are not cleared at reset; a create zeroes its entry before any record can reach it.
module metric_min_max_mean_table
    import mmmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int Q_W   = $bits(t_cmd) + IDX_W;

    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_cmd             front_cmd;
    logic [IDX_W-1:0] front_index;
    logic [Q_W-1:0]   q_out;
    t_cmd             back_cmd;
    logic [IDX_W-1:0] back_index;

    // classification and id allocation
    mmmt_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data (i_in_data),
        .o_in_stall(o_in_stall),
        .i_full    (q_full),
        .o_push    (push),
        .o_cmd     (front_cmd),
        .o_index   (front_index)
    );

    // command queue between front and back
    mmmt_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({front_cmd, front_index}),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_data (q_out)
    );

    assign back_cmd   = q_out[Q_W-1:IDX_W];
    assign back_index = q_out[IDX_W-1:0];

    // table update, mean divider and result register
    mmmt_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (back_cmd),
        .i_q_index  (back_index),
        .o_q_pop    (q_pop),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import mmmt_pkg::*;

    localparam int N_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int DIR_ROWS     = 23;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;

    // one stimulus row: the transaction, and an expected result where it is typed in
    typedef struct {
        t_in  item;
        bit   typed;
        t_out res;
    } t_stim_row;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } t_stall_mode;

    logic i_clk     = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    t_stim_row dir_table [DIR_ROWS];
    t_stim_row stim_q [$];
    t_out      pending_results [$];
    int        accepted_count = 0;
    int        results_seen   = 0;
    int        mismatches     = 0;
    int        cycle_count    = 0;

    // statistics table mirror
    int unsigned              st_used = 0;
    logic signed [DATA_W-1:0] st_min   [N_ENTRIES];
    logic signed [DATA_W-1:0] st_max   [N_ENTRIES];
    longint                   st_sum   [N_ENTRIES];
    logic [DATA_W-1:0]        st_count [N_ENTRIES];

    metric_min_max_mean_table #(
        .TABLE_ENTRIES(N_ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always #2 i_clk = ~i_clk;

    // truncated mean of one entry, zero before the first sample
    function automatic logic signed [DATA_W-1:0] mean_of(input int unsigned idx);
        longint quotient;
        if (st_count[idx] == '0) return '0;
        quotient = st_sum[idx] / longint'({32'd0, st_count[idx]});
        return quotient[DATA_W-1:0];
    endfunction

    // apply one transaction to the mirror and return the result it should give
    function automatic t_out stats_update(input t_in item);
        t_out                     res;
        int unsigned              idx;
        logic signed [DATA_W-1:0] s;
        res = '0;
        s   = item.sample;
        if (item.kind == KIND_CREATE) begin
            if (st_used >= N_ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                idx           = st_used;
                st_min[idx]   = '0;
                st_max[idx]   = '0;
                st_sum[idx]   = 0;
                st_count[idx] = '0;
                st_used       = st_used + 1;
                res.status    = ST_OK;
                res.given_id  = ID_W'(st_used);
            end
        end else if (item.entry_id == '0 || item.entry_id > st_used) begin
            res.status = ST_UNKNOWN;
        end else begin
            idx = item.entry_id - 1;
            if (st_count[idx] == '1) begin
                // count saturated: sample dropped, entry shown as it stands
                res.status = ST_SAT;
            end else begin
                st_count[idx] = st_count[idx] + 1;
                if (st_count[idx] == 1) begin
                    st_min[idx] = s;
                    st_max[idx] = s;
                    st_sum[idx] = longint'(s);
                end else begin
                    if (s < st_min[idx]) st_min[idx] = s;
                    if (s > st_max[idx]) st_max[idx] = s;
                    st_sum[idx] = st_sum[idx] + longint'(s);
                end
                res.status = ST_OK;
            end
            res.minimum      = st_min[idx];
            res.maximum      = st_max[idx];
            res.mean         = mean_of(idx);
            res.samples_seen = st_count[idx];
        end
        return res;
    endfunction

    function automatic t_out summary_of(input t_status st, input logic [ID_W-1:0] gid,
                                        input logic [31:0] mn, input logic [31:0] mx,
                                        input logic [31:0] avg, input logic [31:0] cnt);
        t_out res;
        res.status       = st;
        res.given_id     = gid;
        res.minimum      = mn;
        res.maximum      = mx;
        res.mean         = avg;
        res.samples_seen = cnt;
        return res;
    endfunction

    function automatic t_stim_row record_row(input logic [ID_W-1:0] id, input logic [31:0] s,
                                             input bit typed, input t_out res);
        t_stim_row row;
        row.item.kind     = KIND_RECORD;
        row.item.entry_id = id;
        row.item.sample   = s;
        row.typed         = typed;
        row.res           = res;
        return row;
    endfunction

    function automatic t_stim_row create_row(input logic [ID_W-1:0] id, input logic [31:0] s,
                                             input bit typed, input t_out res);
        t_stim_row row;
        row      = record_row(id, s, typed, res);
        row.item.kind = KIND_CREATE;
        return row;
    endfunction

    // sample mix: full range, small values, near the extremes, powers of two
    function automatic logic [31:0] pick_sample();
        logic [31:0] s;
        case ($urandom_range(0, 7))
            3: begin
                s = $urandom_range(0, 24'hFF_FFFF);
                if ($urandom_range(0, 1) == 1) s = -s;
            end
            4:       s = 32'h8000_0000 + $urandom_range(0, 3);
            5:       s = 32'h7FFF_FFFF - $urandom_range(0, 3);
            6:       s = 32'($urandom_range(0, 3)) - 32'd2;
            7:       s = 32'h0001_0000 << $urandom_range(0, 14);
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches = mismatches + 1;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s expected %h got %h",
                     results_seen, what, want, got);
    endtask

    task automatic compare_result(input t_out want, input t_out got);
        if (got.status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.given_id !== want.given_id)
            flag_mismatch("given_id", 32'(want.given_id), 32'(got.given_id));
        if (got.minimum !== want.minimum)
            flag_mismatch("minimum", want.minimum, got.minimum);
        if (got.maximum !== want.maximum)
            flag_mismatch("maximum", want.maximum, got.maximum);
        if (got.mean !== want.mean)
            flag_mismatch("mean", want.mean, got.mean);
        if (got.samples_seen !== want.samples_seen)
            flag_mismatch("samples_seen", want.samples_seen, got.samples_seen);
    endtask

    // run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL metric_min_max_mean_table");
            $finish;
        end
    end

    // receiver stall pattern, with the mode changed after a randomly drawn span
    t_stall_mode stall_mode  = STALL_NONE;
    int unsigned stall_span  = 0;
    int unsigned stall_phase = 0;
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_span = $urandom_range(50, 400);
        end
        stall_span  = stall_span - 1;
        stall_phase = stall_phase + 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= ((stall_phase % 64) < 40);
        endcase
    end

    // input transaction accepted: predict and queue the expected result
    always @(posedge i_clk) begin : in_monitor
        t_out predicted;
        if (rst_n && in_valid && !in_stall) begin
            predicted = stats_update(in_data);
            if (stim_q[accepted_count].typed)
                pending_results.push_back(stim_q[accepted_count].res);
            else
                pending_results.push_back(predicted);
            accepted_count = accepted_count + 1;
        end
    end

    // output transaction accepted: check against the oldest expectation
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen = results_seen + 1;
            if (pending_results.size() == 0)
                flag_mismatch("result with nothing expected", '0, out_data.mean);
            else
                compare_result(pending_results.pop_front(), out_data);
        end
    end

    initial begin : stimulus
        t_out        unknown_res;
        t_in         item;
        t_stim_row   row;
        int unsigned creates_issued;
        int unsigned live;
        int unsigned roll;
        int          burst;
        int          gap;

        // directed rows: unknown ids, extremes, truncation toward zero, ignored fields
        unknown_res   = summary_of(ST_UNKNOWN, '0, '0, '0, '0, '0);
        dir_table[0]  = record_row(7'd0, 32'h0000_0000, 1, unknown_res);
        dir_table[1]  = record_row(7'd1, 32'h0001_0000, 1, unknown_res);
        dir_table[2]  = record_row(7'd127, 32'hFFFF_FFFF, 1, unknown_res);
        dir_table[3]  = create_row(7'd0, 32'h0000_0000, 1,
                                   summary_of(ST_OK, 7'd1, '0, '0, '0, '0));
        dir_table[4]  = record_row(7'd1, 32'h8000_0000, 1,
                                   summary_of(ST_OK, '0, 32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 32'd1));
        dir_table[5]  = record_row(7'd1, 32'h7FFF_FFFF, 1,
                                   summary_of(ST_OK, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                                              32'd0, 32'd2));
        dir_table[6]  = record_row(7'd1, 32'hFFFF_FFFF, 1,
                                   summary_of(ST_OK, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                                              32'd0, 32'd3));
        dir_table[7]  = record_row(7'd2, 32'h0000_0000, 1, unknown_res);
        dir_table[8]  = create_row(7'h7F, 32'hFFFF_FFFF, 1,
                                   summary_of(ST_OK, 7'd2, '0, '0, '0, '0));
        dir_table[9]  = record_row(7'd2, 32'h0001_0000, 0, '0);
        dir_table[10] = record_row(7'd2, 32'hFFFF_8000, 0, '0);
        dir_table[11] = record_row(7'd2, 32'h0000_0000, 0, '0);
        dir_table[12] = create_row(7'h55, 32'h1234_5678, 1,
                                   summary_of(ST_OK, 7'd3, '0, '0, '0, '0));
        dir_table[13] = record_row(7'd3, 32'h7FFF_FFFF, 0, '0);
        dir_table[14] = record_row(7'd3, 32'h7FFF_FFFF, 0, '0);
        dir_table[15] = record_row(7'd3, 32'h7FFF_FFFF, 0, '0);
        dir_table[16] = record_row(7'd3, 32'h8000_0000, 0, '0);
        dir_table[17] = record_row(7'd3, 32'h8000_0000, 0, '0);
        dir_table[18] = record_row(7'd64, 32'h7FFF_FFFF, 1, unknown_res);
        dir_table[19] = record_row(7'h2A, 32'h5555_5555, 1, unknown_res);
        dir_table[20] = record_row(7'd1, 32'h5555_5555, 0, '0);
        dir_table[21] = record_row(7'd2, 32'hAAAA_AAAA, 0, '0);
        dir_table[22] = record_row(7'd3, 32'h0000_0001, 0, '0);

        creates_issued = 0;
        foreach (dir_table[r]) begin
            stim_q.push_back(dir_table[r]);
            if (dir_table[r].item.kind == KIND_CREATE) creates_issued++;
        end

        // random part: mostly records into live entries, some creates, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            item.kind     = KIND_RECORD;
            item.entry_id = ID_W'($urandom_range(0, 127));
            item.sample   = pick_sample();
            live = (creates_issued < N_ENTRIES) ? creates_issued : N_ENTRIES;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                item.kind      = KIND_CREATE;
                creates_issued = creates_issued + 1;
            end else if (roll < 86 && live > 0) begin
                // a few hot entries build long sums
                if ($urandom_range(0, 3) == 0)
                    item.entry_id = ID_W'($urandom_range(1, (live < 4) ? live : 4));
                else
                    item.entry_id = ID_W'($urandom_range(1, live));
            end
            row.item  = item;
            row.typed = 0;
            row.res   = '0;
            stim_q.push_back(row);
        end

        // reset
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // send in bursts with random gaps
        burst = $urandom_range(1, 24);
        for (int idx = 0; idx < stim_q.size(); idx++) begin
            in_data  <= stim_q[idx].item;
            in_valid <= 1'b1;
            do @(posedge i_clk); while (in_stall);
            burst = burst - 1;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 50);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        in_valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS metric_min_max_mean_table");
        else
            $display("FAIL metric_min_max_mean_table");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mmmt_pkg.sv
rtl/mmmt_front.sv
rtl/mmmt_queue.sv
rtl/mmmt_back.sv
rtl/metric_min_max_mean_table.sv
verif/tb_top.sv
